FILE: rtl/csv_integer_field_parser_defines.svh
// ----------------------------------------------------------------------------
// CSV integer field parser assertion macros
// Shared assertion wrappers. They sample on clk and are disabled while rst_n
// is low. In synthesis builds they expand to nothing.
// ----------------------------------------------------------------------------
`ifndef CSV_INTEGER_FIELD_PARSER_DEFINES_SVH
`define CSV_INTEGER_FIELD_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// Checks that a property holds at every clock edge out of reset.
`define CIFP_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("cifp assertion failed");
// Checks that a condition never holds at a clock edge out of reset.
`define CIFP_NEVER(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("cifp forbidden condition seen");
`else
`define CIFP_ASSERT(name, prop)
`define CIFP_NEVER(name, cond)
`endif

`endif

FILE: rtl/cifp_pkg.sv
// ----------------------------------------------------------------------------
// CSV integer field parser package
// Types, character codes, register indexes and reset values shared by the
// parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cifp_pkg;

    localparam int BYTE_WIDTH       = 8;
    localparam int VALUE_WIDTH      = 32;
    localparam int LENGTH_WIDTH_DEF = 16;
    localparam int CFG_INDEX_WIDTH  = 2;

    localparam logic [BYTE_WIDTH-1:0] CH_LF    = 8'd10;
    localparam logic [BYTE_WIDTH-1:0] CH_CR    = 8'd13;
    localparam logic [BYTE_WIDTH-1:0] CH_SPACE = 8'd32;
    localparam logic [BYTE_WIDTH-1:0] CH_PLUS  = 8'd43;
    localparam logic [BYTE_WIDTH-1:0] CH_MINUS = 8'd45;
    localparam logic [BYTE_WIDTH-1:0] CH_ZERO  = 8'd48;
    localparam logic [BYTE_WIDTH-1:0] CH_NINE  = 8'd57;

    localparam logic [BYTE_WIDTH-1:0] SEPARATOR_RESET   = 8'd44;
    localparam logic [BYTE_WIDTH-1:0] QUOTE_CHAR_RESET  = 8'd34;
    localparam logic [BYTE_WIDTH-1:0] ESCAPE_CHAR_RESET = 8'd92;

    // Largest magnitudes for a positive and for a negative value.
    localparam logic [VALUE_WIDTH-1:0] MAG_LIMIT_POS = 32'h7FFF_FFFF;
    localparam logic [VALUE_WIDTH-1:0] MAG_LIMIT_NEG = 32'h8000_0000;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_SEPARATOR   = 2'd0,
        REG_QUOTE_CHAR  = 2'd1,
        REG_ESCAPE_CHAR = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_SCAN   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [BYTE_WIDTH-1:0] separator;
        logic [BYTE_WIDTH-1:0] quote_char;
        logic [BYTE_WIDTH-1:0] escape_char;
    } cfg_t;

    // Per-field parse state, except the length counter whose width is a
    // module parameter.
    typedef struct packed {
        logic                   in_quote;
        logic                   take_literal;
        logic                   cr_pending;
        phase_t                 phase;
        logic                   negative;
        logic [VALUE_WIDTH-1:0] magnitude;
        logic                   overflowed;
    } field_state_t;

    typedef struct packed {
        logic                          emit;
        logic signed [VALUE_WIDTH-1:0] int_value;
        logic                          record_end;
        logic                          overflow;
    } field_result_t;

endpackage

`default_nettype wire

FILE: rtl/cifp_step.sv
// ----------------------------------------------------------------------------
// CSV integer field parser step
// Next-state and result logic for one text byte: prefix handling, digit
// accumulation with saturation, and the quote-aware delimiter scan.
// ----------------------------------------------------------------------------
`default_nettype none

module cifp_step #(
    parameter int LENGTH_WIDTH = cifp_pkg::LENGTH_WIDTH_DEF
) (
    input  cifp_pkg::cfg_t                          cfg,
    input  cifp_pkg::field_state_t                  state,
    input  logic [LENGTH_WIDTH-1:0]                 length_count,
    input  logic [cifp_pkg::BYTE_WIDTH-1:0]         text_byte,
    output cifp_pkg::field_state_t                  state_next,
    output logic [LENGTH_WIDTH-1:0]                 length_next,
    output cifp_pkg::field_result_t                 result,
    output logic [LENGTH_WIDTH-1:0]                 result_length
);
    import cifp_pkg::*;

    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = {LENGTH_WIDTH{1'b1}};
    localparam int ACC_WIDTH = VALUE_WIDTH + 4;

    logic                    at_sign;
    logic                    sign_taken;
    logic                    at_digits;
    logic                    is_digit;
    logic                    digit_taken;
    logic                    do_scan;
    logic [ACC_WIDTH-1:0]    acc;
    logic [ACC_WIDTH-1:0]    acc_limit;
    logic [3:0]              digit;
    logic                    cr_hit;
    logic [LENGTH_WIDTH-1:0] len_after_cr;
    logic [LENGTH_WIDTH-1:0] len_counted;
    logic                    emit;
    logic                    rec_end;

    // The prefix sections fall into one another within the same byte.
    assign at_sign     = ((state.phase == PH_SKIP) && (text_byte != CH_SPACE))
                       || (state.phase == PH_SIGN);
    assign sign_taken  = at_sign && ((text_byte == CH_MINUS) || (text_byte == CH_PLUS));
    assign at_digits   = (at_sign && !sign_taken) || (state.phase == PH_DIGITS);
    assign is_digit    = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
    assign digit_taken = at_digits && is_digit;
    assign do_scan     = (state.phase == PH_SCAN) || (at_digits && !is_digit);

    // magnitude * 10 + digit, as (m << 3) + (m << 1) + digit.
    assign digit     = 4'(text_byte - CH_ZERO);
    assign acc       = ({4'b0, state.magnitude} << 3) + ({4'b0, state.magnitude} << 1)
                     + {{VALUE_WIDTH{1'b0}}, digit};
    assign acc_limit = {4'b0, (state.negative ? MAG_LIMIT_NEG : MAG_LIMIT_POS)};

    assign cr_hit       = state.cr_pending && (text_byte == CH_LF);
    assign len_after_cr = (state.cr_pending && (length_count != LEN_MAX))
                        ? length_count + 1'b1 : length_count;
    assign len_counted  = (len_after_cr != LEN_MAX) ? len_after_cr + 1'b1 : len_after_cr;

    always_comb
    begin
        state_next  = state;
        length_next = length_count;
        emit        = 1'b0;
        rec_end     = 1'b0;
        result_length = length_count;

        if (sign_taken)
        begin
            state_next.phase = PH_DIGITS;
            if (text_byte == CH_MINUS)
            begin
                state_next.negative = 1'b1;
            end
        end
        else if (digit_taken)
        begin
            state_next.phase = PH_DIGITS;
            if (acc > acc_limit)
            begin
                state_next.magnitude  = acc_limit[VALUE_WIDTH-1:0];
                state_next.overflowed = 1'b1;
            end
            else
            begin
                state_next.magnitude = acc[VALUE_WIDTH-1:0];
            end
        end
        else if (do_scan)
        begin
            state_next.phase      = PH_SCAN;
            state_next.cr_pending = 1'b0;
            if (cr_hit)
            begin
                emit          = 1'b1;
                rec_end       = 1'b1;
                result_length = length_count;
            end
            else if (state.in_quote)
            begin
                length_next = len_counted;
                if (state.take_literal)
                begin
                    state_next.take_literal = 1'b0;
                end
                else if (text_byte == cfg.escape_char)
                begin
                    state_next.take_literal = 1'b1;
                end
                else if (text_byte == cfg.quote_char)
                begin
                    state_next.in_quote = 1'b0;
                end
            end
            else
            begin
                priority if (text_byte == cfg.quote_char)
                begin
                    state_next.in_quote = 1'b1;
                    length_next         = len_counted;
                end
                else if (text_byte == cfg.separator)
                begin
                    emit          = 1'b1;
                    result_length = len_after_cr;
                end
                else if (text_byte == CH_LF)
                begin
                    emit          = 1'b1;
                    rec_end       = 1'b1;
                    result_length = len_after_cr;
                end
                else if (text_byte == CH_CR)
                begin
                    state_next.cr_pending = 1'b1;
                    length_next           = len_after_cr;
                end
                else
                begin
                    length_next = len_counted;
                end
            end
        end

        // A finished field restarts the prefix; quote state carries over.
        if (emit)
        begin
            state_next.phase        = PH_SKIP;
            state_next.negative     = 1'b0;
            state_next.magnitude    = '0;
            state_next.overflowed   = 1'b0;
            state_next.take_literal = 1'b0;
            state_next.cr_pending   = 1'b0;
            length_next             = '0;
        end
    end

    assign result.emit       = emit;
    assign result.int_value  = state.negative ? $signed(32'd0 - state.magnitude)
                                              : $signed(state.magnitude);
    assign result.record_end = rec_end;
    assign result.overflow   = state.overflowed;

endmodule

`default_nettype wire

FILE: rtl/csv_integer_field_parser.sv
// ----------------------------------------------------------------------------
// CSV integer field parser
// Splits a byte stream of delimited text into fields and returns the leading
// signed integer, the length and the record-end flag of every field.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                                       | Direction
//  ---------+-----------------------------------------------+----------
//  input    | in_valid, in_stall, text_byte                 | in
//  output   | out_valid, out_stall, int_value, field_length,| out
//           | record_end, overflow                          |
//  config   | cfg_we, cfg_index, cfg_wdata                  | in
//
// One byte per cycle while in_stall is low: a byte is captured in the input
// register, and the step logic loads its result, if it ends a field, into the
// output register. Parse state fed back through the step logic sets the rate.
// An asynchronous active-low reset restores the register reset values and
// clears all parse state. A stalled output holds its result; the input stalls
// only while a byte is waiting and the output register is full and stalled.
`default_nettype none

module csv_integer_field_parser #(
    parameter int LENGTH_WIDTH = cifp_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // Configuration write port.
    input  logic                                    cfg_we,
    input  logic [cifp_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [cifp_pkg::BYTE_WIDTH-1:0]         cfg_wdata,
    // Byte input channel.
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [cifp_pkg::BYTE_WIDTH-1:0]         text_byte,
    // Field result channel.
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [cifp_pkg::VALUE_WIDTH-1:0] int_value,
    output logic [LENGTH_WIDTH-1:0]                 field_length,
    output logic                                    record_end,
    output logic                                    overflow
);
    import cifp_pkg::*;

    `include "csv_integer_field_parser_defines.svh"

    // Configuration registers.
    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Input register.
    logic [BYTE_WIDTH-1:0] byte_reg;
    logic [BYTE_WIDTH-1:0] byte_next;
    logic                  byte_valid_reg;
    logic                  byte_valid_next;

    // Parse state.
    field_state_t            state_reg;
    field_state_t            state_next;
    logic [LENGTH_WIDTH-1:0] length_reg;
    logic [LENGTH_WIDTH-1:0] length_next;

    // Result register.
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic signed [VALUE_WIDTH-1:0] int_value_reg;
    logic signed [VALUE_WIDTH-1:0] int_value_next;
    logic [LENGTH_WIDTH-1:0]       field_length_reg;
    logic [LENGTH_WIDTH-1:0]       field_length_next;
    logic                          record_end_reg;
    logic                          record_end_next;
    logic                          overflow_reg;
    logic                          overflow_next;

    // Step logic outputs.
    field_state_t            step_state;
    logic [LENGTH_WIDTH-1:0] step_length;
    field_result_t           step_result;
    logic [LENGTH_WIDTH-1:0] step_result_length;

    logic out_free;
    logic advance;
    logic in_take;

    cifp_step #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_step (
        .cfg           (cfg_reg),
        .state         (state_reg),
        .length_count  (length_reg),
        .text_byte     (byte_reg),
        .state_next    (step_state),
        .length_next   (step_length),
        .result        (step_result),
        .result_length (step_result_length)
    );

    // The held byte is processed as soon as the result register can take
    // whatever it produces.
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = byte_valid_reg && out_free;
    assign in_stall = byte_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SEPARATOR:   cfg_next.separator   = cfg_wdata;
                REG_QUOTE_CHAR:  cfg_next.quote_char  = cfg_wdata;
                REG_ESCAPE_CHAR: cfg_next.escape_char = cfg_wdata;
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        byte_next       = in_take ? text_byte : byte_reg;
        byte_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : byte_valid_reg);

        state_next  = advance ? step_state : state_reg;
        length_next = advance ? step_length : length_reg;

        out_valid_next    = out_valid_reg && out_stall;
        int_value_next    = int_value_reg;
        field_length_next = field_length_reg;
        record_end_next   = record_end_reg;
        overflow_next     = overflow_reg;
        if (advance && step_result.emit)
        begin
            out_valid_next    = 1'b1;
            int_value_next    = step_result.int_value;
            field_length_next = step_result_length;
            record_end_next   = step_result.record_end;
            overflow_next     = step_result.overflow;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.separator   <= SEPARATOR_RESET;
            cfg_reg.quote_char  <= QUOTE_CHAR_RESET;
            cfg_reg.escape_char <= ESCAPE_CHAR_RESET;
            byte_valid_reg      <= 1'b0;
            state_reg           <= '0;
            length_reg          <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            cfg_reg        <= cfg_next;
            byte_valid_reg <= byte_valid_next;
            state_reg      <= state_next;
            length_reg     <= length_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        byte_reg         <= byte_next;
        int_value_reg    <= int_value_next;
        field_length_reg <= field_length_next;
        record_end_reg   <= record_end_next;
        overflow_reg     <= overflow_next;
    end

    assign out_valid    = out_valid_reg;
    assign int_value    = int_value_reg;
    assign field_length = field_length_reg;
    assign record_end   = record_end_reg;
    assign overflow     = overflow_reg;

    // A pending CR is only ever recorded outside a quoted section.
    `CIFP_NEVER(a_cr_outside_quote, state_reg.cr_pending && state_reg.in_quote)
    // A literal byte is only expected inside a quoted section.
    `CIFP_NEVER(a_literal_in_quote, state_reg.take_literal && !state_reg.in_quote)
    // The saturated magnitude of a positive value stays below 2^31.
    `CIFP_NEVER(a_mag_limit, (!state_reg.negative && state_reg.magnitude[VALUE_WIDTH-1])
        || (state_reg.magnitude > MAG_LIMIT_NEG))
    // Bytes are counted only once the prefix is over.
    `CIFP_NEVER(a_len_in_scan, (length_reg != '0) && (state_reg.phase != PH_SCAN))
    // A finished field always lands in the result register.
    `CIFP_ASSERT(a_emit_lands, (advance && step_result.emit) |=> out_valid_reg)

endmodule

`default_nettype wire
